// ===== src/assert_macros.svh =====
// Assertion macros used by the checker file of this block.
// Requires nothing else; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion, disabled while the active-low reset is asserted
`define DTTF_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Concurrent assertion that is also checked across reset
`define DTTF_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== src/dttf_pkg.sv =====
// Package for the decimal text to fixed-point converter: widths, character
// codes and the power-of-ten divisor table. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package dttf_pkg;

    // Number format
    localparam int FRAC_BITS       = 16;
    localparam int INT_BITS        = 31;
    localparam int MAX_FRAC_DIGITS = 9;

    // Field and register widths
    localparam int CH_W    = 8;
    localparam int VALUE_W = 48;
    localparam int WHOLE_W = INT_BITS;
    localparam int FDIG_W  = 30;                        // 10^9 - 1 fits
    localparam int FCNT_W  = 4;
    localparam int DIV_W   = 30;                        // 10^9 fits
    localparam int MAG_W   = WHOLE_W + FRAC_BITS + 1;
    localparam int STEP_W  = $clog2(FRAC_BITS + 1);
    localparam int PHASE_W = 3;

    localparam logic [WHOLE_W-1:0] WHOLE_MAX = {WHOLE_W{1'b1}};
    localparam logic [MAG_W-1:0]   POS_MAX   = MAG_W'((64'd1 << (VALUE_W - 1)) - 64'd1);
    localparam logic [MAG_W-1:0]   NEG_MAX   = MAG_W'(64'd1 << (VALUE_W - 1));
    localparam logic [FCNT_W-1:0]  FCNT_MAX  = FCNT_W'(MAX_FRAC_DIGITS);

    // Character codes
    localparam logic [CH_W-1:0] CH_ZERO  = 8'd48;
    localparam logic [CH_W-1:0] CH_NINE  = 8'd57;
    localparam logic [CH_W-1:0] CH_DOT   = 8'h2E;
    localparam logic [CH_W-1:0] CH_PLUS  = 8'h2B;
    localparam logic [CH_W-1:0] CH_MINUS = 8'h2D;
    localparam logic [CH_W-1:0] CH_TAB   = 8'd9;
    localparam logic [CH_W-1:0] CH_CR    = 8'd13;
    localparam logic [CH_W-1:0] CH_SPACE = 8'd32;

    // 10^n for n = 0..9; larger counts clamp to 10^9
    function automatic logic [DIV_W-1:0] pow10(input logic [FCNT_W-1:0] n);
        logic [DIV_W-1:0] p;
        case (n)
            4'd0:    p = 30'd1;
            4'd1:    p = 30'd10;
            4'd2:    p = 30'd100;
            4'd3:    p = 30'd1000;
            4'd4:    p = 30'd10000;
            4'd5:    p = 30'd100000;
            4'd6:    p = 30'd1000000;
            4'd7:    p = 30'd10000000;
            4'd8:    p = 30'd100000000;
            default: p = 30'd1000000000;
        endcase
        return p;
    endfunction

endpackage

`default_nettype wire

// ===== src/decimal_text_to_fixed_core.sv =====
// Decimal text to signed Q.16 fixed-point converter, top level.
// Depends on dttf_pkg.
//
//  channel | dir | tdata                   | tuser        | tlast
//  s_      | in  | [7:0] ch                 | -            | last character
//  m_      | out | [47:0] value (signed)    | [0] saturated| -
//
// Each character is parsed in the cycle it is transferred.
// A character with tlast starts a restoring divide of the fraction digits by
// 10^count, one quotient bit per cycle, then the final state builds the
// magnitude and sign.
// s_tready is low while the divider runs and during the final state.
// The result sits in an output register; the final state waits on m_tready
// only if the previous result has not been taken.
// aresetn is synchronous; it clears the parser and drops m_tvalid.
`timescale 1ns / 1ps
`default_nettype none

module decimal_text_to_fixed_core (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] ch
    input  wire logic        s_tlast,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [47:0]      m_tdata,   // [47:0] value
    output logic [0:0]       m_tuser    // [0] saturated
);

    // Sequencer states
    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_DIV   = 2'd1;
    localparam logic [1:0] ST_FINAL = 2'd2;

    // Parser phases
    localparam logic [dttf_pkg::PHASE_W-1:0] PH_SPACE = 3'd0;
    localparam logic [dttf_pkg::PHASE_W-1:0] PH_SIGN  = 3'd1;
    localparam logic [dttf_pkg::PHASE_W-1:0] PH_INT   = 3'd2;
    localparam logic [dttf_pkg::PHASE_W-1:0] PH_FRAC  = 3'd3;
    localparam logic [dttf_pkg::PHASE_W-1:0] PH_DONE  = 3'd4;

    logic [1:0]                        state_reg, state_next;
    logic [dttf_pkg::PHASE_W-1:0]      phase_reg, phase_next;
    logic                              neg_reg, neg_next;
    logic [dttf_pkg::WHOLE_W-1:0]      whole_reg, whole_next;
    logic                              ovf_reg, ovf_next;
    logic [dttf_pkg::FDIG_W-1:0]       fdv_reg, fdv_next;
    logic [dttf_pkg::FCNT_W-1:0]       fcnt_reg, fcnt_next;
    logic [dttf_pkg::DIV_W-1:0]        rem_reg, rem_next;
    logic [dttf_pkg::DIV_W-1:0]        divisor_reg, divisor_next;
    logic [dttf_pkg::FRAC_BITS-1:0]    quo_reg, quo_next;
    logic [dttf_pkg::STEP_W-1:0]       step_reg, step_next;
    logic                              m_tvalid_reg, m_tvalid_next;
    logic [dttf_pkg::VALUE_W-1:0]      value_reg, value_next;
    logic                              sat_reg, sat_next;

    logic                              s_xfer;
    logic                              is_digit, is_space;
    logic [3:0]                        digit;
    logic [dttf_pkg::WHOLE_W+3:0]      whole_sum;
    logic [dttf_pkg::FDIG_W-1:0]       frac_sum;
    logic [dttf_pkg::DIV_W:0]          rem_dbl;
    logic                              rem_ge;
    logic [dttf_pkg::FRAC_BITS-1:0]    frac_q;
    logic [dttf_pkg::MAG_W-1:0]        max_mag, mag_sum, mag_sel;
    logic                              fin_sat;
    logic                              out_free;

    assign s_tready = (state_reg == ST_IDLE);
    assign s_xfer   = s_tvalid && s_tready;
    assign out_free = !m_tvalid_reg || m_tready;

    // Character classes and digit arithmetic (x10 as shift-add)
    always_comb begin
        is_digit  = s_tdata inside {[dttf_pkg::CH_ZERO:dttf_pkg::CH_NINE]};
        is_space  = s_tdata inside {[dttf_pkg::CH_TAB:dttf_pkg::CH_CR], dttf_pkg::CH_SPACE};
        digit     = s_tdata[3:0];
        whole_sum = ({4'd0, whole_reg} << 3) + ({4'd0, whole_reg} << 1)
                  + {{dttf_pkg::WHOLE_W{1'b0}}, digit};
        frac_sum  = (fdv_reg << 3) + (fdv_reg << 1)
                  + {{(dttf_pkg::FDIG_W-4){1'b0}}, digit};
    end

    // Divider step: one restoring subtract per cycle
    always_comb begin
        rem_dbl = {rem_reg, 1'b0};
        rem_ge  = (rem_dbl >= {1'b0, divisor_reg});
    end

    // Final magnitude, clamp and sign
    always_comb begin
        frac_q  = ovf_reg ? {dttf_pkg::FRAC_BITS{1'b1}} : quo_reg;
        max_mag = neg_reg ? dttf_pkg::NEG_MAX : dttf_pkg::POS_MAX;
        mag_sum = ({1'b0, whole_reg, {dttf_pkg::FRAC_BITS{1'b0}}})
                + {{(dttf_pkg::MAG_W-dttf_pkg::FRAC_BITS){1'b0}}, frac_q};
        fin_sat = ovf_reg;
        mag_sel = mag_sum;
        if (({1'b0, whole_reg}) > (max_mag >> dttf_pkg::FRAC_BITS)) begin
            mag_sel = max_mag;
            fin_sat = 1'b1;
        end else if (mag_sum > max_mag) begin
            mag_sel = max_mag;
            fin_sat = 1'b1;
        end
    end

    // Parser and sequencer
    always_comb begin
        state_next    = state_reg;
        phase_next    = phase_reg;
        neg_next      = neg_reg;
        whole_next    = whole_reg;
        ovf_next      = ovf_reg;
        fdv_next      = fdv_reg;
        fcnt_next     = fcnt_reg;
        rem_next      = rem_reg;
        divisor_next  = divisor_reg;
        quo_next      = quo_reg;
        step_next     = step_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        value_next    = value_reg;
        sat_next      = sat_reg;

        case (state_reg)
            ST_IDLE: begin
                if (s_xfer) begin
                    // one character of the field
                    case (phase_reg)
                        PH_SPACE: begin
                            if (is_space) begin
                                phase_next = PH_SPACE;
                            end else if (s_tdata == dttf_pkg::CH_PLUS
                                         || s_tdata == dttf_pkg::CH_MINUS) begin
                                neg_next   = (s_tdata == dttf_pkg::CH_MINUS);
                                phase_next = PH_SIGN;
                            end else if (is_digit) begin
                                phase_next = PH_INT;
                            end else if (s_tdata == dttf_pkg::CH_DOT) begin
                                phase_next = PH_FRAC;
                            end else begin
                                phase_next = PH_DONE;
                            end
                        end
                        PH_SIGN: begin
                            if (is_digit) begin
                                phase_next = PH_INT;
                            end else begin
                                neg_next   = 1'b0;
                                phase_next = PH_DONE;
                            end
                        end
                        PH_INT: begin
                            if (is_digit) begin
                                phase_next = PH_INT;
                            end else if (s_tdata == dttf_pkg::CH_DOT) begin
                                phase_next = PH_FRAC;
                            end else begin
                                phase_next = PH_DONE;
                            end
                        end
                        PH_FRAC: begin
                            if (is_digit) begin
                                if (fcnt_reg < dttf_pkg::FCNT_MAX) begin
                                    fdv_next  = frac_sum;
                                    fcnt_next = fcnt_reg + 1'b1;
                                end
                            end else begin
                                phase_next = PH_DONE;
                            end
                        end
                        default: phase_next = PH_DONE;
                    endcase

                    // integer digit accumulate with saturation
                    if (is_digit && !ovf_reg
                        && (phase_reg == PH_SPACE || phase_reg == PH_SIGN
                            || phase_reg == PH_INT)) begin
                        if (whole_sum > {4'd0, dttf_pkg::WHOLE_MAX}) begin
                            whole_next = dttf_pkg::WHOLE_MAX;
                            ovf_next   = 1'b1;
                        end else begin
                            whole_next = whole_sum[dttf_pkg::WHOLE_W-1:0];
                        end
                    end

                    // end of field: load the divider
                    if (s_tlast) begin
                        rem_next     = fdv_next;
                        divisor_next = dttf_pkg::pow10(fcnt_next);
                        quo_next     = '0;
                        step_next    = dttf_pkg::STEP_W'(dttf_pkg::FRAC_BITS);
                        state_next   = ST_DIV;
                    end
                end
            end
            ST_DIV: begin
                if (rem_ge) begin
                    rem_next = dttf_pkg::DIV_W'(rem_dbl - {1'b0, divisor_reg});
                end else begin
                    rem_next = rem_dbl[dttf_pkg::DIV_W-1:0];
                end
                quo_next  = {quo_reg[dttf_pkg::FRAC_BITS-2:0], rem_ge};
                step_next = step_reg - 1'b1;
                if (step_reg == dttf_pkg::STEP_W'(1)) begin
                    state_next = ST_FINAL;
                end
            end
            ST_FINAL: begin
                if (out_free) begin
                    m_tvalid_next = 1'b1;
                    value_next    = neg_reg ? dttf_pkg::VALUE_W'(~mag_sel + 1'b1)
                                            : dttf_pkg::VALUE_W'(mag_sel);
                    sat_next      = fin_sat;
                    // parser back to its initial state
                    phase_next    = PH_SPACE;
                    neg_next      = 1'b0;
                    whole_next    = '0;
                    ovf_next      = 1'b0;
                    fdv_next      = '0;
                    fcnt_next     = '0;
                    state_next    = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            phase_reg    <= PH_SPACE;
            neg_reg      <= 1'b0;
            whole_reg    <= '0;
            ovf_reg      <= 1'b0;
            fdv_reg      <= '0;
            fcnt_reg     <= '0;
            step_reg     <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            phase_reg    <= phase_next;
            neg_reg      <= neg_next;
            whole_reg    <= whole_next;
            ovf_reg      <= ovf_next;
            fdv_reg      <= fdv_next;
            fcnt_reg     <= fcnt_next;
            step_reg     <= step_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    // Datapath registers, no reset
    always_ff @(posedge aclk) begin
        rem_reg     <= rem_next;
        divisor_reg <= divisor_next;
        quo_reg     <= quo_next;
        value_reg   <= value_next;
        sat_reg     <= sat_next;
    end

    assign m_tvalid   = m_tvalid_reg;
    assign m_tdata    = value_reg;
    assign m_tuser[0] = sat_reg;

endmodule

`default_nettype wire

// ===== src/dttf_checker.sv =====
// Port-level checker for decimal_text_to_fixed_core, attached by bind.
// Depends on assert_macros.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module dttf_checker (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        s_tvalid,
    input wire logic        s_tready,
    input wire logic        s_tlast,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [47:0] m_tdata,
    input wire logic [0:0]  m_tuser
);

    // Stalled result holds
    `DTTF_ASSERT(a_out_hold, aclk, aresetn, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser), "result changed while stalled")

    // Reset drops the result
    `DTTF_ASSERT_ALWAYS(a_reset_clears, aclk, !aresetn |=> !m_tvalid, "m_tvalid high after reset")

    // The last character starts the divide: input side goes busy
    `DTTF_ASSERT(a_busy_after_last, aclk, aresetn, s_tvalid && s_tready && s_tlast |=> !s_tready, "input ready right after last character")

    // A new result is only produced out of the busy final step
    `DTTF_ASSERT(a_result_from_busy, aclk, aresetn, $rose(m_tvalid) |-> $past(!s_tready), "result appeared while input side was idle")

endmodule

bind decimal_text_to_fixed_core dttf_checker u_dttf_checker (.*);

`default_nettype wire

// ===== test/tb_decimal_text_to_fixed_core.sv =====
// Testbench for decimal_text_to_fixed_core: drives character fields through the
// input stream and checks every fixed-point result against a built-in parser.
// Depends on dttf_pkg and the core RTL.
`timescale 1ns / 1ps

module tb_decimal_text_to_fixed_core;

    localparam int CYCLE_LIMIT = 300000;
    localparam int STIM_CHARS  = 700;
    localparam int HOLD_CYCLES = 400;

    typedef enum logic [2:0] {
        SCAN_SPACE,
        SCAN_SIGN,
        SCAN_INT,
        SCAN_FRAC,
        SCAN_DONE
    } scan_phase_t;

    typedef struct {
        logic [dttf_pkg::CH_W-1:0] ch;
        logic                      last;
        bit                        drain;     // wait for all results before offering
    } char_item_t;

    typedef struct {
        logic [dttf_pkg::VALUE_W-1:0] value;
        logic                         saturated;
    } fixed_result_t;

    // DUT signals
    logic               aclk     = 1'b0;
    logic               aresetn  = 1'b0;
    logic               s_tvalid = 1'b0;
    logic               s_tready;
    logic [7:0]         s_tdata  = '0;  // [7:0] ch
    logic               s_tlast  = 1'b0;
    logic               m_tvalid;
    logic               m_tready = 1'b0;
    logic [47:0]        m_tdata;        // [47:0] value
    logic [0:0]         m_tuser;        // [0] saturated

    // Stimulus and expectations
    char_item_t                char_q[$];
    char_item_t                in_flight;
    logic [dttf_pkg::CH_W-1:0] field_chars[$];
    fixed_result_t             expected_values[$];
    int                        cycle_cnt  = 0;
    int                        chars_sent = 0;
    int                        hold_left  = 0;
    bit                        hold_done  = 1'b0;
    int                        send_gap   = 0;
    int                        recv_gap   = 0;
    int                        errors     = 0;

    // Parser state
    scan_phase_t                  scan_phase = SCAN_SPACE;
    logic                         sign_neg   = 1'b0;
    logic [dttf_pkg::WHOLE_W-1:0] whole_acc  = '0;
    logic [dttf_pkg::FDIG_W-1:0]  frac_acc   = '0;
    logic [dttf_pkg::FCNT_W-1:0]  frac_cnt   = '0;
    logic                         whole_ovf  = 1'b0;

    decimal_text_to_fixed_core u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Cycle count, reset release and timeout
    always @(posedge aclk) begin
        cycle_cnt <= cycle_cnt + 1;
        aresetn   <= (cycle_cnt >= 10);
        if (cycle_cnt == CYCLE_LIMIT) begin
            $display("tb_decimal_text_to_fixed_core failed");
            $finish;
        end
    end

    // Periodic windows with no idling on either side
    function automatic int pick_gap();
        if (cycle_cnt[11:10] == 2'b11)
            return 0;
        return $urandom_range(0, 10);
    endfunction

    function automatic bit is_white(logic [dttf_pkg::CH_W-1:0] c);
        return (c >= dttf_pkg::CH_TAB && c <= dttf_pkg::CH_CR) || c == dttf_pkg::CH_SPACE;
    endfunction

    function automatic bit is_digit(logic [dttf_pkg::CH_W-1:0] c);
        return c >= dttf_pkg::CH_ZERO && c <= dttf_pkg::CH_NINE;
    endfunction

    task automatic flag_mismatch(string what, logic [63:0] got, logic [63:0] want);
        errors++;
        $display("mismatch on %s: got %h, want %h (cycle %0d)", what, got, want, cycle_cnt);
    endtask

    // Integer digit with saturation at 2^INT_BITS - 1
    task automatic add_whole_digit(logic [3:0] d);
        logic [63:0] top;
        logic [63:0] limit;
        top   = (64'd1 << dttf_pkg::INT_BITS) - 64'd1;
        limit = (top - d) / 64'd10;
        if (!whole_ovf) begin
            if (64'(whole_acc) > limit) begin
                whole_acc = dttf_pkg::WHOLE_W'(top);
                whole_ovf = 1'b1;
            end else begin
                whole_acc = dttf_pkg::WHOLE_W'(64'(whole_acc) * 64'd10 + d);
            end
        end
    endtask

    // Build the result for the finished field and clear the parser
    task automatic close_field();
        logic [63:0]   maxmag;
        logic [63:0]   mag;
        logic [63:0]   fracq;
        logic [63:0]   divisor;
        fixed_result_t res;
        res.saturated = whole_ovf;
        maxmag = sign_neg ? (64'd1 << (dttf_pkg::VALUE_W - 1))
                          : (64'd1 << (dttf_pkg::VALUE_W - 1)) - 64'd1;
        divisor = 64'd1;
        for (int i = 0; i < frac_cnt; i++)
            divisor = divisor * 64'd10;
        fracq = (64'(frac_acc) << dttf_pkg::FRAC_BITS) / divisor;
        if (whole_ovf)
            fracq = (64'd1 << dttf_pkg::FRAC_BITS) - 64'd1;
        if (64'(whole_acc) > (maxmag >> dttf_pkg::FRAC_BITS)) begin
            mag = maxmag;
            res.saturated = 1'b1;
        end else begin
            mag = (64'(whole_acc) << dttf_pkg::FRAC_BITS) + fracq;
            if (mag > maxmag) begin
                mag = maxmag;
                res.saturated = 1'b1;
            end
        end
        res.value = sign_neg ? dttf_pkg::VALUE_W'(64'd0 - mag) : dttf_pkg::VALUE_W'(mag);
        expected_values.push_back(res);
        scan_phase = SCAN_SPACE;
        sign_neg   = 1'b0;
        whole_acc  = '0;
        frac_acc   = '0;
        frac_cnt   = '0;
        whole_ovf  = 1'b0;
    endtask

    // One accepted character through the parser
    task automatic take_character(logic [dttf_pkg::CH_W-1:0] c, logic last);
        case (scan_phase)
            SCAN_SPACE: begin
                if (is_white(c)) begin
                end else if (c == dttf_pkg::CH_PLUS || c == dttf_pkg::CH_MINUS) begin
                    sign_neg   = (c == dttf_pkg::CH_MINUS);
                    scan_phase = SCAN_SIGN;
                end else if (is_digit(c)) begin
                    add_whole_digit(4'(c - dttf_pkg::CH_ZERO));
                    scan_phase = SCAN_INT;
                end else if (c == dttf_pkg::CH_DOT) begin
                    scan_phase = SCAN_FRAC;
                end else begin
                    scan_phase = SCAN_DONE;
                end
            end
            SCAN_SIGN: begin
                if (is_digit(c)) begin
                    add_whole_digit(4'(c - dttf_pkg::CH_ZERO));
                    scan_phase = SCAN_INT;
                end else begin
                    sign_neg   = 1'b0;
                    scan_phase = SCAN_DONE;
                end
            end
            SCAN_INT: begin
                if (is_digit(c))
                    add_whole_digit(4'(c - dttf_pkg::CH_ZERO));
                else if (c == dttf_pkg::CH_DOT)
                    scan_phase = SCAN_FRAC;
                else
                    scan_phase = SCAN_DONE;
            end
            SCAN_FRAC: begin
                if (is_digit(c)) begin
                    if (frac_cnt < dttf_pkg::FCNT_MAX) begin
                        frac_acc = dttf_pkg::FDIG_W'(64'(frac_acc) * 64'd10
                                                     + (c - dttf_pkg::CH_ZERO));
                        frac_cnt = frac_cnt + 1'b1;
                    end
                end else begin
                    scan_phase = SCAN_DONE;
                end
            end
            default: scan_phase = SCAN_DONE;
        endcase
        if (last)
            close_field();
    endtask

    // Field assembly
    task automatic add_text(string text);
        for (int i = 0; i < text.len(); i++)
            field_chars.push_back(text[i]);
    endtask

    task automatic add_digits(int count);
        repeat (count)
            field_chars.push_back(dttf_pkg::CH_W'(dttf_pkg::CH_ZERO + $urandom_range(0, 9)));
    endtask

    task automatic emit_field(bit drain);
        char_item_t item;
        for (int i = 0; i < field_chars.size(); i++) begin
            item.ch    = field_chars[i];
            item.last  = (i == field_chars.size() - 1);
            item.drain = drain && (i == 0);
            char_q.push_back(item);
        end
        field_chars.delete();
    endtask

    // Mostly well-formed numbers with random content; some noise
    task automatic build_random_field();
        int          pick;
        longint      near_max;
        pick = $urandom_range(0, 9);
        if (pick == 0) begin
            repeat ($urandom_range(1, 6))
                field_chars.push_back(dttf_pkg::CH_W'($urandom_range(0, 255)));
        end else begin
            repeat ($urandom_range(0, 2)) begin
                pick = $urandom_range(9, 14);
                field_chars.push_back(pick == 14 ? dttf_pkg::CH_SPACE : dttf_pkg::CH_W'(pick));
            end
            if ($urandom_range(0, 2) == 0)
                field_chars.push_back($urandom_range(0, 1) ? dttf_pkg::CH_MINUS
                                                           : dttf_pkg::CH_PLUS);
            if ($urandom_range(0, 7) == 0) begin
                // integer part around the saturation point
                near_max = 64'd2147483637 + $urandom_range(0, 20);
                add_text($sformatf("%0d", near_max));
            end else if ($urandom_range(0, 3) == 0) begin
                add_digits($urandom_range(7, 12));
            end else begin
                add_digits($urandom_range(0, 5));
            end
            if ($urandom_range(0, 3) != 0) begin
                field_chars.push_back(dttf_pkg::CH_DOT);
                if ($urandom_range(0, 3) == 0)
                    add_digits($urandom_range(8, 12));
                else
                    add_digits($urandom_range(0, 5));
            end
            if ($urandom_range(0, 3) == 0)
                repeat ($urandom_range(1, 3))
                    field_chars.push_back(dttf_pkg::CH_W'($urandom_range(0, 255)));
        end
        if (field_chars.size() == 0)
            field_chars.push_back(dttf_pkg::CH_W'($urandom_range(0, 255)));
    endtask

    // Stimulus, then wait for the last result
    initial begin : stimulus
        int fields;
        // NUL byte alone
        field_chars.push_back(8'h00);
        emit_field(1'b0);
        // sign followed by a period
        add_text("-.");
        emit_field(1'b0);
        // sign as the last character
        add_text("+");
        emit_field(1'b0);
        // negative zero
        add_text("-0");
        emit_field(1'b0);
        // integer overflow, then an all-ones byte that ends parsing
        add_text("5000000000");
        field_chars.push_back(8'hFF);
        emit_field(1'b0);
        // lone period with more fraction digits than are kept
        add_text(".1234567891");
        emit_field(1'b0);

        fields = 0;
        while (char_q.size() < STIM_CHARS) begin
            build_random_field();
            emit_field(fields % 20 == 0);
            fields++;
        end

        wait (aresetn);
        do
            @(negedge aclk);
        while (char_q.size() != 0 || s_tvalid || expected_values.size() != 0);
        repeat (40) @(posedge aclk);
        if (errors == 0)
            $display("tb_decimal_text_to_fixed_core passed");
        else
            $display("tb_decimal_text_to_fixed_core failed");
        $finish;
    end

    // Driver: offer queued characters, predict each transfer
    always @(posedge aclk) begin : drive
        logic next_valid;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            send_gap  = pick_gap();
        end else begin
            next_valid = s_tvalid;
            if (s_tvalid && s_tready) begin
                take_character(in_flight.ch, in_flight.last);
                chars_sent <= chars_sent + 1;
                next_valid = 1'b0;
                send_gap   = pick_gap();
            end else if (!s_tvalid && send_gap != 0) begin
                send_gap--;
            end
            if (!next_valid && send_gap == 0 && char_q.size() != 0 &&
                !(char_q[0].drain && expected_values.size() != 0)) begin
                in_flight = char_q.pop_front();
                s_tdata   <= in_flight.ch;
                s_tlast   <= in_flight.last;
                next_valid = 1'b1;
            end
            s_tvalid <= next_valid;
        end
    end

    // Long receiver hold-off once, midway through the random part
    always @(posedge aclk) begin
        if (!aresetn) begin
            hold_left <= 0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end else if (!hold_done && chars_sent >= 350) begin
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
        end
    end

    // Monitor: check each result transfer against the oldest expectation
    always @(posedge aclk) begin : observe
        fixed_result_t want;
        if (!aresetn) begin
            m_tready <= 1'b0;
            recv_gap  = pick_gap();
        end else begin
            if (m_tvalid && m_tready) begin
                if (expected_values.size() == 0) begin
                    flag_mismatch("unexpected result", 64'(m_tdata), 64'd0);
                end else begin
                    want = expected_values.pop_front();
                    if (m_tdata !== want.value)
                        flag_mismatch("value", 64'(m_tdata), 64'(want.value));
                    if (m_tuser[0] !== want.saturated)
                        flag_mismatch("saturated", 64'(m_tuser), 64'(want.saturated));
                end
                recv_gap = pick_gap();
            end else if (recv_gap != 0) begin
                recv_gap--;
            end
            m_tready <= (recv_gap == 0) && (hold_left == 0);
        end
    end

endmodule
